// ----- design/tlmd_pkg.sv -----
// Package for the type-length message deframer.
// Holds the channel item types and result kind codes; no dependencies.
package tlmd_pkg;

  localparam int LEN_W = 31;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_EMPTY   = 2'd1;
  localparam kind_t KIND_ERROR   = 2'd2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_chunk;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] msg_type;
    logic [LEN_W-1:0]   msg_length;
    logic [7:0]         payload_byte;
    logic               last_of_message;
  } out_item_t;

endpackage

// ----- design/tlmd_front.sv -----
// Front end of the deframer: header collection, length check, payload
// count and chunk discard. Produces at most one result per byte. Uses tlmd_pkg.
module tlmd_front import tlmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             byte_valid,
  input  in_item_t         byte_item,
  output logic             res_valid,
  output out_item_t        res_item
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0]      hdr_r, hdr_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] limit_r;

  logic [63:0]      hdr_shift;
  logic [63:0]      hdr_view;
  logic [31:0]      len_word;
  logic             len_bad;

  assign hdr_shift = {hdr_r[55:0], byte_item.byte_in};
  assign len_word  = hdr_shift[31:0];
  assign len_bad   = len_word[31] || (len_word > {1'b0, limit_r});

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    hdr_nxt     = hdr_r;
    left_nxt    = left_r;
    res_valid   = 1'b0;
    hdr_view    = hdr_r;
    res_item.kind            = KIND_PAYLOAD;
    res_item.payload_byte    = 8'd0;
    res_item.last_of_message = 1'b1;
    if (byte_valid) begin
      unique case (phase_r)
        PH_DISCARD: begin
          if (byte_item.end_of_chunk) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_PAYLOAD: begin
          res_valid                = 1'b1;
          res_item.payload_byte    = byte_item.byte_in;
          res_item.last_of_message = (left_r <= LEN_W'(1));
          if (left_r != '0) begin
            left_nxt = left_r - LEN_W'(1);
          end
          if (left_r <= LEN_W'(1)) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          hdr_nxt     = hdr_shift;
          hdr_view    = hdr_shift;
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          if (hdr_cnt_r == 3'd7) begin
            priority if (len_bad) begin
              res_valid     = 1'b1;
              res_item.kind = KIND_ERROR;
              phase_nxt     = byte_item.end_of_chunk ? PH_HEADER : PH_DISCARD;
            end else if (len_word == 32'd0) begin
              res_valid     = 1'b1;
              res_item.kind = KIND_EMPTY;
              phase_nxt     = PH_HEADER;
            end else begin
              left_nxt  = len_word[LEN_W-1:0];
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      endcase
    end
    res_item.msg_type   = hdr_view[63:32];
    res_item.msg_length = hdr_view[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 3'd0;
      hdr_r     <= 64'd0;
      left_r    <= '0;
      limit_r   <= LEN_W'(65536);
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      hdr_r     <= hdr_nxt;
      left_r    <= left_nxt;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
    end
  end

endmodule

// ----- design/tlmd_queue.sv -----
// Short result queue between the front end and the output stage.
// Register-array FIFO with one write and one read port. Uses tlmd_pkg.
module tlmd_queue import tlmd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_item_t wr_item,
  input  logic      rd_en,
  output out_item_t rd_item,
  output logic      q_full,
  output logic      q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/tlmd_back.sv -----
// Output stage of the deframer: pulls results from the queue into a
// holding register shown on the result channel. Uses tlmd_pkg.
module tlmd_back import tlmd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  out_item_t q_item,
  output logic      q_rd,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic      valid_r;
  out_item_t data_r;

  // Refill when the register is free or drained this cycle.
  assign q_rd     = !q_empty && (!valid_r || pop);
  assign empty    = !valid_r;
  assign out_item = data_r;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      data_r <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_rd) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ----- design/type_length_message_deframer.sv -----
// Top level of the type-length message deframer.
// Instantiates tlmd_front, tlmd_queue and tlmd_back; uses tlmd_pkg.
//
// Usage:
//   Input channel: drive in_item (one stream byte plus end_of_chunk) and
//   raise push; a transfer happens at a clock edge with push high and full
//   low. One byte can be taken every cycle.
//   Result channel: while empty is low, out_item holds the oldest result;
//   raise pop to transfer it. Each 8-byte header (type word, then length
//   word, big-endian) is followed by that many payload bytes, one result per
//   payload byte. A zero length gives one empty result; a length with the
//   top bit set or above the limit gives one error result and the rest of
//   the current chunk is dropped.
//   Configuration: cfg_we with cfg_data writes the length limit (reset
//   65536); write only while the block is idle.
// Path: a result passes from the front end into the queue, then from the
//   queue into the output register. Throughput is one byte per cycle
//   while full is low, set by the front end.
// Reset: synchronous, active low; returns to header collection, clears the
//   queue and the output register.
// Stall: when pop is held low the output register holds, the queue fills
//   and full rises after QUEUE_DEPTH more results; bytes that produce no
//   result still need full low to transfer.
module type_length_message_deframer import tlmd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data
);

  logic      byte_xfer;
  logic      res_valid;
  out_item_t res_item;
  logic      q_rd, q_empty;
  out_item_t q_item;

  // Hold off input while the queue has no room for a possible result.
  assign byte_xfer = push && !full;

  tlmd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .byte_valid (byte_xfer),
    .byte_item  (in_item),
    .res_valid  (res_valid),
    .res_item   (res_item)
  );

  tlmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_item (res_item),
    .rd_en   (q_rd),
    .rd_item (q_item),
    .q_full  (full),
    .q_empty (q_empty)
  );

  tlmd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// ----- design/tlmd_checker.sv -----
// Port-level checker for the deframer, bound to the top level.
// Uses tlmd_pkg.
module tlmd_checker import tlmd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result shown right after reset");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.kind != KIND_PAYLOAD) |-> out_item.last_of_message)
    else $error("empty or error result without last mark");

  a_marker_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.kind != KIND_PAYLOAD) |-> (out_item.payload_byte == 8'd0))
    else $error("empty or error result carries a payload byte");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.kind == KIND_PAYLOAD || out_item.kind == KIND_EMPTY ||
                out_item.kind == KIND_ERROR))
    else $error("undefined result kind");

endmodule

bind type_length_message_deframer tlmd_checker u_tlmd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

// ----- dv/tb_top.sv -----
// Testbench for type_length_message_deframer: directed table, then random messages.
// Checks results against typed-in rows or a deframer model; depends on tlmd_pkg, RTL.
`timescale 1ns / 1ps

module tb_top;
  import tlmd_pkg::*;

  localparam int ITEMS_PER_SEG = 250;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 31'd65536;
  localparam logic [LEN_W-1:0] LIMIT_MAX   = '1;

  typedef enum logic [1:0] {PH_COLLECT, PH_PAYLOAD, PH_DROP} deframe_phase_t;

  // One row of the directed table; lit holds a typed-in result where has_lit is set.
  typedef struct packed {
    logic [7:0] data;
    logic       eoc;
    logic       has_lit;
    out_item_t  lit;
  } stim_row_t;

  localparam out_item_t NO_RESULT = '0;

  // Directed rows: empty message with extreme type, negative length whose header
  // ends the chunk (nothing dropped), length above the reset limit followed by
  // dropped bytes up to the chunk end, then a one-byte payload.
  localparam stim_row_t DIRECTED_ROWS [35] = '{
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b1, '{KIND_EMPTY, 32'hFFFF_FFFF, 31'd0, 8'd0, 1'b1}},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b1, '{KIND_ERROR, 32'h0000_0000, 31'h7FFF_FFFF, 8'd0, 1'b1}},
    '{8'h80, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b1, '{KIND_ERROR, 32'h8000_0000, 31'h0001_0001, 8'd0, 1'b1}},
    '{8'hA5, 1'b0, 1'b0, NO_RESULT},
    '{8'h3C, 1'b1, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b1, '{KIND_PAYLOAD, 32'h7FFF_FFFF, 31'd1, 8'hFF, 1'b1}}
  };

  // DUT ports; every input starts at a known value.
  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             push     = 1'b0;
  logic             full;
  in_item_t         in_item  = '0;
  logic             empty;
  logic             pop      = 1'b0;
  out_item_t        out_item;
  logic             cfg_we   = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;

  // Deframer model state and its copy of the length limit.
  deframe_phase_t   pr_phase   = PH_COLLECT;
  logic [2:0]       pr_hdr_cnt = '0;
  logic [63:0]      pr_hdr     = '0;
  logic [LEN_W-1:0] pr_left    = '0;
  logic [LEN_W-1:0] pr_limit   = LIMIT_RESET;

  out_item_t expected_results[$];
  in_item_t  pending_bytes[$];

  int tx_idle_pct = 18;
  int rx_idle_pct = 51;
  int fail_count  = 0;
  int n_bytes     = 0;
  int n_useful    = 0;
  int n_payload   = 0;
  int n_empty     = 0;
  int n_error     = 0;
  int stall_cycles = 0;

  type_length_message_deframer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Build a result from the header currently held by the model.
  function automatic out_item_t header_result(input kind_t kind, input logic [7:0] pbyte,
                                              input logic last);
    out_item_t r;
    r.kind            = kind;
    r.msg_type        = pr_hdr[63:32];
    r.msg_length      = pr_hdr[30:0];
    r.payload_byte    = pbyte;
    r.last_of_message = last;
    return r;
  endfunction

  // Advance the deframer model by one stream byte; produced flags a result.
  function automatic void deframe_byte(input in_item_t it, output logic produced,
                                       output out_item_t res);
    logic [31:0] len_word;
    produced = 1'b0;
    res      = NO_RESULT;
    case (pr_phase)
      PH_DROP: begin
        // drop everything up to and including the chunk end
        if (it.end_of_chunk) pr_phase = PH_COLLECT;
      end
      PH_PAYLOAD: begin
        res      = header_result(KIND_PAYLOAD, it.byte_in, pr_left <= 1);
        produced = 1'b1;
        if (pr_left > 0) pr_left = pr_left - LEN_W'(1);
        if (pr_left == 0) pr_phase = PH_COLLECT;
      end
      default: begin
        pr_hdr     = {pr_hdr[55:0], it.byte_in};
        pr_hdr_cnt = pr_hdr_cnt + 3'd1;
        if (pr_hdr_cnt == 0) begin
          len_word = pr_hdr[31:0];
          produced = 1'b1;
          if (len_word[31] || len_word > {1'b0, pr_limit}) begin
            res      = header_result(KIND_ERROR, 8'd0, 1'b1);
            // a header that closes its chunk leaves nothing to drop
            pr_phase = it.end_of_chunk ? PH_COLLECT : PH_DROP;
          end else if (len_word == 0) begin
            res      = header_result(KIND_EMPTY, 8'd0, 1'b1);
            pr_phase = PH_COLLECT;
          end else begin
            produced = 1'b0;
            pr_left  = len_word[30:0];
            pr_phase = PH_PAYLOAD;
          end
        end
      end
    endcase
  endfunction

  // Compare one popped result with the oldest expected one, field by field.
  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result with none expected: kind %0d type %0h length %0h byte %0h",
             got.kind, got.msg_type, got.msg_length, got.payload_byte);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      fail_count++;
    end
    if (got.msg_type !== want.msg_type) begin
      $error("msg_type: expected %0h, got %0h", want.msg_type, got.msg_type);
      fail_count++;
    end
    if (got.msg_length !== want.msg_length) begin
      $error("msg_length: expected %0h, got %0h", want.msg_length, got.msg_length);
      fail_count++;
    end
    if (got.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
      fail_count++;
    end
    if (got.last_of_message !== want.last_of_message) begin
      $error("last_of_message: expected %0b, got %0b", want.last_of_message,
             got.last_of_message);
      fail_count++;
    end
    case (want.kind)
      KIND_PAYLOAD: n_payload++;
      KIND_EMPTY:   n_empty++;
      default:      n_error++;
    endcase
  endfunction

  // Offer one byte, idling at random first; predict at the edge of the transfer.
  // A typed-in result, where given, replaces the model's own.
  task automatic send_byte(input in_item_t it, input logic has_lit, input out_item_t lit);
    logic      produced;
    out_item_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    n_bytes++;
    if (pr_phase != PH_DROP) n_useful++;
    deframe_byte(it, produced, res);
    if (has_lit) expected_results = {expected_results, lit};
    else if (produced) expected_results = {expected_results, res};
  endtask

  task automatic stage_byte(input logic [7:0] b, input logic e);
    pending_bytes = {pending_bytes, in_item_t'({b, e})};
  endtask

  // Stage one message: mostly well-formed headers and payloads with random
  // content, some bad lengths with a dropped tail, and raw noise when the
  // limit is small enough to keep misaligned lengths short.
  task automatic build_message();
    logic [31:0] len;
    logic [63:0] hdr;
    logic        err;
    logic        hdr_eoc;
    int          sel;
    sel = $urandom_range(99);
    if (pr_limit <= 64 && sel < 8) begin
      repeat ($urandom_range(6, 1))
        stage_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      return;
    end
    sel = $urandom_range(99);
    if (sel < 10) len = 32'd0;
    else if (sel < 22) len = 32'h8000_0000 | $urandom;
    else if (sel < 32) begin
      if (pr_limit == LIMIT_MAX) len = 32'h8000_0000 | $urandom;
      else len = {1'b0, pr_limit} + 32'd1 + $urandom_range(1000);
    end else if (sel < 38 && pr_limit <= 32) len = {1'b0, pr_limit};
    else len = $urandom_range(12, 1);
    err = len[31] || len > {1'b0, pr_limit};
    hdr = {$urandom, len};
    hdr_eoc = 1'b0;
    for (int i = 0; i < 8; i++) begin
      // chunk ends fall on message boundaries more often than inside them
      hdr_eoc = (i == 7) ? ($urandom_range(2) == 0) : ($urandom_range(15) == 0);
      stage_byte(hdr[63-8*i -: 8], hdr_eoc);
    end
    if (err) begin
      if (!hdr_eoc) begin
        repeat ($urandom_range(4)) stage_byte(8'($urandom_range(255)), 1'b0);
        stage_byte(8'($urandom_range(255)), 1'b1);
      end
    end else begin
      for (int i = 0; i < len; i++)
        stage_byte(8'($urandom_range(255)),
                   (i == len - 1) ? ($urandom_range(2) == 0) : ($urandom_range(15) == 0));
    end
  endtask

  // Hold the sender until every expected result has arrived, then let the
  // pipeline settle so no byte without a result is still in flight.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: check each transfer, then decide at random whether to pop next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(out_item);
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run when nothing transfers on either side for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int               seg_start;
    logic [LEN_W-1:0] lim;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at the reset limit
    foreach (DIRECTED_ROWS[i])
      send_byte({DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].eoc}, DIRECTED_ROWS[i].has_lit,
                DIRECTED_ROWS[i].lit);

    // six random segments: reset limit, zero, maximum, small, any, twelve
    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        tx_idle_pct = 18;
        rx_idle_pct = 51;
      end else if (seg < 4) begin
        tx_idle_pct = 51;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (seg > 0) begin
        // steer the stream back to a header boundary before the limit moves
        while (pr_phase != PH_COLLECT || pr_hdr_cnt != 0) begin
          if (pr_phase == PH_DROP)
            send_byte({8'($urandom_range(255)), 1'b1}, 1'b0, NO_RESULT);
          else if (pr_phase == PH_PAYLOAD)
            send_byte({8'($urandom_range(255)), 1'($urandom_range(1))}, 1'b0, NO_RESULT);
          else send_byte({8'hFF, 1'b1}, 1'b0, NO_RESULT);
        end
        wait_drained();
        case (seg)
          1:       lim = '0;
          2:       lim = LIMIT_MAX;
          3:       lim = LEN_W'($urandom_range(20, 1));
          4:       lim = LEN_W'($urandom);
          default: lim = 31'd12;
        endcase
        cfg_we   <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pr_limit = lim;
      end
      seg_start = n_useful;
      while (n_useful < seg_start + ITEMS_PER_SEG) begin
        build_message();
        while (pending_bytes.size() != 0)
          send_byte(pending_bytes.pop_front(), 1'b0, NO_RESULT);
      end
    end

    wait_drained();
    $display("Run covered %0d stream bytes (%0d outside drop) across six length limits.",
             n_bytes, n_useful);
    $display("Results checked: %0d payload, %0d empty, %0d length error.",
             n_payload, n_empty, n_error);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
